>>> sv/smmd_pkg.sv
// Shared types, constants and region codes for the segmented memory map decoder.
`timescale 1ns / 1ps

package smmd_pkg;

    // Default window sizes in bytes.
    localparam int MAIN_BYTES_DEF       = 2097152;
    localparam int PARALLEL_BYTES_DEF   = 65536;
    localparam int SCRATCH_BYTES_DEF    = 1024;
    localparam int IO_BYTES_DEF         = 8192;
    localparam int BOOT_BYTES_DEF       = 524288;
    localparam int CACHE_CTRL_BYTES_DEF = 512;

    // Segment and physical base addresses.
    localparam logic [31:0] KSEG0_BASE    = 32'h8000_0000;
    localparam logic [31:0] KSEG1_BASE    = 32'ha000_0000;
    localparam logic [31:0] KSEG2_BASE    = 32'hfffe_0000;
    localparam logic [31:0] PARALLEL_BASE = 32'h1f00_0000;
    localparam logic [31:0] SCRATCH_BASE  = 32'h1f80_0000;
    localparam logic [31:0] IO_BASE       = 32'h1f80_1000;
    localparam logic [31:0] BOOT_BASE     = 32'h1fc0_0000;

    // Segment codes taken from the top three address bits.
    localparam logic [2:0] SEG_KSEG0  = 3'd4;
    localparam logic [2:0] SEG_KSEG1  = 3'd5;
    localparam logic [2:0] SEG_UNUSED = 3'd6;
    localparam logic [2:0] SEG_KSEG2  = 3'd7;

    // Access size codes.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    // Operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // Byte index width: covers windows of up to 2**23 bytes.
    localparam int IDX_W    = 23;
    localparam int IO_OFF_W = 13;
    localparam int LANES    = 4;

    // Queue between front and back ends.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        RGN_NONE = 3'd0,
        RGN_MAIN = 3'd1,
        RGN_PAR  = 3'd2,
        RGN_SCR  = 3'd3,
        RGN_IO   = 3'd4,
        RGN_BOOT = 3'd5,
        RGN_CC   = 3'd6
    } t_region;

    // One classified access as handed from the front end to the back end.
    typedef struct packed {
        logic                               op;
        logic [1:0]                         size;
        logic [1:0]                         last;
        logic                               bus_err;
        t_region [LANES-1:0]                rgn;
        logic [LANES-1:0][IDX_W-1:0]        idx;
        logic [31:0]                        wdata;
        logic                               io_req;
        logic [IO_OFF_W-1:0]                io_off;
        logic [31:0]                        io_wdata;
    } t_item;

endpackage

>>> sv/segmented_memory_map_decoder.sv
// Path: the front end registers an accepted access and classifies it, the queue holds it,
// the back end walks its bytes (1, 2 or 4) and the result register presents it; a bus error
// skips the byte walk. The back end has a single byte port per region memory and takes one byte
// of the access each cycle; the front end can take new accesses while the queue has room.
// Reset is synchronous and clears control state only; memory contents stay undefined until
// written. Results are presented for one cycle on o_valid and cannot be stalled.
`timescale 1ns / 1ps

module segmented_memory_map_decoder #(
    parameter int MAIN_BYTES       = smmd_pkg::MAIN_BYTES_DEF,
    parameter int PARALLEL_BYTES   = smmd_pkg::PARALLEL_BYTES_DEF,
    parameter int SCRATCH_BYTES    = smmd_pkg::SCRATCH_BYTES_DEF,
    parameter int IO_BYTES         = smmd_pkg::IO_BYTES_DEF,
    parameter int BOOT_BYTES       = smmd_pkg::BOOT_BYTES_DEF,
    parameter int CACHE_CTRL_BYTES = smmd_pkg::CACHE_CTRL_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_operation,
    input  logic [1:0]                      i_access_size,
    input  logic [31:0]                     i_address,
    input  logic [31:0]                     i_write_data,
    output logic                            o_valid,
    output logic [31:0]                     o_read_data,
    output logic                            o_access_fault,
    output logic                            o_io_request,
    output logic                            o_io_write,
    output logic [smmd_pkg::IO_OFF_W-1:0]   o_io_offset,
    output logic [1:0]                      o_io_size,
    output logic [31:0]                     o_io_write_data
);

    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_empty;
    smmd_pkg::t_item    w_front_item;
    smmd_pkg::t_item    w_back_item;

    smmd_front #(
        .MAIN_BYTES       (MAIN_BYTES),
        .PARALLEL_BYTES   (PARALLEL_BYTES),
        .SCRATCH_BYTES    (SCRATCH_BYTES),
        .IO_BYTES         (IO_BYTES),
        .BOOT_BYTES       (BOOT_BYTES),
        .CACHE_CTRL_BYTES (CACHE_CTRL_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_operation   (i_operation),
        .i_access_size (i_access_size),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .i_full        (w_full),
        .o_busy        (busy),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    smmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_back_item)
    );

    smmd_back #(
        .MAIN_BYTES       (MAIN_BYTES),
        .PARALLEL_BYTES   (PARALLEL_BYTES),
        .SCRATCH_BYTES    (SCRATCH_BYTES),
        .BOOT_BYTES       (BOOT_BYTES),
        .CACHE_CTRL_BYTES (CACHE_CTRL_BYTES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_empty),
        .i_item          (w_back_item),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .o_read_data     (o_read_data),
        .o_access_fault  (o_access_fault),
        .o_io_request    (o_io_request),
        .o_io_write      (o_io_write),
        .o_io_offset     (o_io_offset),
        .o_io_size       (o_io_size),
        .o_io_write_data (o_io_write_data)
    );

endmodule

>>> sv/smmd_front.sv
// Front end: registers an accepted access and classifies each of its bytes by region.
`timescale 1ns / 1ps

module smmd_front #(
    parameter int MAIN_BYTES       = smmd_pkg::MAIN_BYTES_DEF,
    parameter int PARALLEL_BYTES   = smmd_pkg::PARALLEL_BYTES_DEF,
    parameter int SCRATCH_BYTES    = smmd_pkg::SCRATCH_BYTES_DEF,
    parameter int IO_BYTES         = smmd_pkg::IO_BYTES_DEF,
    parameter int BOOT_BYTES       = smmd_pkg::BOOT_BYTES_DEF,
    parameter int CACHE_CTRL_BYTES = smmd_pkg::CACHE_CTRL_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_operation,
    input  logic [1:0]          i_access_size,
    input  logic [31:0]         i_address,
    input  logic [31:0]         i_write_data,
    input  logic                i_full,
    output logic                o_busy,
    output logic                o_push,
    output smmd_pkg::t_item     o_item
);

    logic        r_valid;
    logic        n_valid;
    logic        r_op;
    logic [1:0]  r_size;
    logic [31:0] r_addr;
    logic [31:0] r_wdata;

    logic                          w_accept;
    logic [31:0]                   w_a    [smmd_pkg::LANES];
    logic [31:0]                   w_p    [smmd_pkg::LANES];
    smmd_pkg::t_region             w_rgn  [smmd_pkg::LANES];
    logic [smmd_pkg::IDX_W-1:0]    w_idx  [smmd_pkg::LANES];
    logic [smmd_pkg::LANES-1:0]    w_lane_on;
    logic [1:0]                    w_last;
    logic                          w_err;
    logic                          w_any_io;
    logic [1:0]                    w_first_io;
    logic [31:0]                   w_wd_masked;

    assign o_busy   = r_valid && i_full;
    assign w_accept = i_start && !o_busy;
    assign o_push   = r_valid && !i_full;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_operation;
            r_size  <= i_access_size;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
    end

    // Per-byte decode; the byte address wraps at 32 bits.
    always_comb begin
        for (int k = 0; k < smmd_pkg::LANES; k++) begin
            w_a[k] = r_addr + 32'(k);
            if (w_a[k][31:29] == smmd_pkg::SEG_KSEG0) begin
                w_p[k] = w_a[k] - smmd_pkg::KSEG0_BASE;
            end else if (w_a[k][31:29] == smmd_pkg::SEG_KSEG1) begin
                w_p[k] = w_a[k] - smmd_pkg::KSEG1_BASE;
            end else begin
                w_p[k] = w_a[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < smmd_pkg::LANES; k++) begin
            w_rgn[k] = smmd_pkg::RGN_NONE;
            w_idx[k] = '0;
            unique case (w_a[k][31:29])
                smmd_pkg::SEG_KSEG2: begin
                    if (w_a[k] >= smmd_pkg::KSEG2_BASE &&
                        (w_a[k] - smmd_pkg::KSEG2_BASE) < 32'(CACHE_CTRL_BYTES)) begin
                        w_rgn[k] = smmd_pkg::RGN_CC;
                        w_idx[k] = smmd_pkg::IDX_W'(w_a[k] - smmd_pkg::KSEG2_BASE);
                    end
                end
                smmd_pkg::SEG_UNUSED: begin
                    w_rgn[k] = smmd_pkg::RGN_NONE;
                end
                default: begin
                    if (w_p[k] < 32'(MAIN_BYTES)) begin
                        w_rgn[k] = smmd_pkg::RGN_MAIN;
                        w_idx[k] = smmd_pkg::IDX_W'(w_p[k]);
                    end else if (w_p[k] >= smmd_pkg::PARALLEL_BASE &&
                        (w_p[k] - smmd_pkg::PARALLEL_BASE) < 32'(PARALLEL_BYTES)) begin
                        w_rgn[k] = smmd_pkg::RGN_PAR;
                        w_idx[k] = smmd_pkg::IDX_W'(w_p[k] - smmd_pkg::PARALLEL_BASE);
                    end else if (w_p[k] >= smmd_pkg::SCRATCH_BASE &&
                        (w_p[k] - smmd_pkg::SCRATCH_BASE) < 32'(SCRATCH_BYTES)) begin
                        w_rgn[k] = smmd_pkg::RGN_SCR;
                        w_idx[k] = smmd_pkg::IDX_W'(w_p[k] - smmd_pkg::SCRATCH_BASE);
                    end else if (w_p[k] >= smmd_pkg::IO_BASE &&
                        (w_p[k] - smmd_pkg::IO_BASE) < 32'(IO_BYTES)) begin
                        w_rgn[k] = smmd_pkg::RGN_IO;
                        w_idx[k] = smmd_pkg::IDX_W'(w_p[k] - smmd_pkg::IO_BASE);
                    end else if (w_p[k] >= smmd_pkg::BOOT_BASE &&
                        (w_p[k] - smmd_pkg::BOOT_BASE) < 32'(BOOT_BYTES)) begin
                        w_rgn[k] = smmd_pkg::RGN_BOOT;
                        w_idx[k] = smmd_pkg::IDX_W'(w_p[k] - smmd_pkg::BOOT_BASE);
                    end
                end
            endcase
        end
    end

    always_comb begin
        unique case (r_size)
            smmd_pkg::SIZE_BYTE: begin
                w_last      = 2'd0;
                w_wd_masked = {24'd0, r_wdata[7:0]};
            end
            smmd_pkg::SIZE_HALF: begin
                w_last      = 2'd1;
                w_wd_masked = {16'd0, r_wdata[15:0]};
            end
            default: begin
                w_last      = 2'd3;
                w_wd_masked = r_wdata;
            end
        endcase
    end

    always_comb begin
        w_err      = (r_size == smmd_pkg::SIZE_BAD);
        w_any_io   = 1'b0;
        w_first_io = 2'd0;
        for (int k = 0; k < smmd_pkg::LANES; k++) begin
            w_lane_on[k] = (2'(k) <= w_last);
            if (w_lane_on[k] && w_rgn[k] == smmd_pkg::RGN_NONE) begin
                w_err = 1'b1;
            end
        end
        // Walk downward so the lowest IO lane wins.
        for (int k = smmd_pkg::LANES - 1; k >= 0; k--) begin
            if (w_lane_on[k] && w_rgn[k] == smmd_pkg::RGN_IO) begin
                w_any_io   = 1'b1;
                w_first_io = 2'(k);
            end
        end
    end

    always_comb begin
        o_item         = '0;
        o_item.op      = r_op;
        o_item.size    = r_size;
        o_item.last    = w_last;
        o_item.bus_err = w_err;
        o_item.wdata   = w_wd_masked;
        for (int k = 0; k < smmd_pkg::LANES; k++) begin
            o_item.rgn[k] = w_rgn[k];
            o_item.idx[k] = w_idx[k];
        end
        o_item.io_req = !w_err && w_any_io;
        if (o_item.io_req) begin
            o_item.io_off = w_idx[w_first_io][smmd_pkg::IO_OFF_W-1:0];
            if (r_op == smmd_pkg::OP_STORE) begin
                o_item.io_wdata = w_wd_masked >> {w_first_io, 3'b000};
            end
        end
    end

endmodule

>>> sv/smmd_queue.sv
// Short queue of classified accesses between the front and back ends.
`timescale 1ns / 1ps

module smmd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  smmd_pkg::t_item     i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output smmd_pkg::t_item     o_item
);

    localparam int PTR_W = $clog2(smmd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(smmd_pkg::QUEUE_DEPTH + 1);

    smmd_pkg::t_item    r_slot [smmd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = (r_count == CNT_W'(smmd_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_item    = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(smmd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(smmd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> sv/smmd_back.sv
// Back end: walks the bytes of one access through the region memories and forms the result.
`timescale 1ns / 1ps

module smmd_back #(
    parameter int MAIN_BYTES       = smmd_pkg::MAIN_BYTES_DEF,
    parameter int PARALLEL_BYTES   = smmd_pkg::PARALLEL_BYTES_DEF,
    parameter int SCRATCH_BYTES    = smmd_pkg::SCRATCH_BYTES_DEF,
    parameter int BOOT_BYTES       = smmd_pkg::BOOT_BYTES_DEF,
    parameter int CACHE_CTRL_BYTES = smmd_pkg::CACHE_CTRL_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    input  smmd_pkg::t_item                 i_item,
    output logic                            o_pop,
    output logic                            o_valid,
    output logic [31:0]                     o_read_data,
    output logic                            o_access_fault,
    output logic                            o_io_request,
    output logic                            o_io_write,
    output logic [smmd_pkg::IO_OFF_W-1:0]   o_io_offset,
    output logic [1:0]                      o_io_size,
    output logic [31:0]                     o_io_write_data
);

    localparam int MAIN_AW = $clog2(MAIN_BYTES);
    localparam int PAR_AW  = $clog2(PARALLEL_BYTES);
    localparam int SCR_AW  = $clog2(SCRATCH_BYTES);
    localparam int BOOT_AW = $clog2(BOOT_BYTES);
    localparam int CC_AW   = $clog2(CACHE_CTRL_BYTES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    smmd_pkg::t_item    r_item;
    logic [1:0]         r_k;
    logic [31:0]        r_rd;
    logic [31:0]        n_rd;
    logic               r_pend;
    logic [1:0]         r_pend_k;
    smmd_pkg::t_region  r_pend_rgn;

    logic [7:0] r_main_mem [MAIN_BYTES];
    logic [7:0] r_par_mem  [PARALLEL_BYTES];
    logic [7:0] r_scr_mem  [SCRATCH_BYTES];
    logic [7:0] r_boot_mem [BOOT_BYTES];
    logic [7:0] r_cc_mem   [CACHE_CTRL_BYTES];
    logic [7:0] r_main_q;
    logic [7:0] r_par_q;
    logic [7:0] r_scr_q;
    logic [7:0] r_boot_q;
    logic [7:0] r_cc_q;

    logic                        r_out_valid;
    logic [31:0]                 r_read_data;
    logic                        r_access_fault;
    logic                        r_io_request;
    logic                        r_io_write;
    logic [smmd_pkg::IO_OFF_W-1:0] r_io_offset;
    logic [1:0]                  r_io_size;
    logic [31:0]                 r_io_write_data;

    logic                        w_run;
    logic                        w_store;
    smmd_pkg::t_region           w_rgn;
    logic [smmd_pkg::IDX_W-1:0]  w_idx;
    logic [7:0]                  w_wbyte;
    logic [7:0]                  w_rbyte;

    assign o_pop = (r_state == S_IDLE || r_state == S_DONE) && !i_empty;

    assign w_run   = (r_state == S_RUN);
    assign w_store = w_run && (r_item.op == smmd_pkg::OP_STORE);
    assign w_rgn   = r_item.rgn[r_k];
    assign w_idx   = r_item.idx[r_k];
    assign w_wbyte = r_item.wdata[{r_k, 3'b000} +: 8];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = i_item.bus_err ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (r_k == r_item.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (o_pop) begin
                    n_state = i_item.bus_err ? S_DONE : S_RUN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= w_run;
            r_out_valid <= (r_state == S_DONE);
        end
    end

    // Byte walk: one memory access per cycle, read data merged in the cycle after.
    always_ff @(posedge i_clk) begin
        r_pend_k   <= r_k;
        r_pend_rgn <= w_rgn;
        if (o_pop) begin
            r_item <= i_item;
            r_k    <= 2'd0;
            r_rd   <= '0;
        end else begin
            r_rd <= n_rd;
            if (w_run) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_comb begin
        case (r_pend_rgn)
            smmd_pkg::RGN_MAIN: w_rbyte = r_main_q;
            smmd_pkg::RGN_PAR:  w_rbyte = r_par_q;
            smmd_pkg::RGN_SCR:  w_rbyte = r_scr_q;
            smmd_pkg::RGN_BOOT: w_rbyte = r_boot_q;
            smmd_pkg::RGN_CC:   w_rbyte = r_cc_q;
            default:            w_rbyte = 8'd0;
        endcase
    end

    always_comb begin
        n_rd = r_rd;
        if (r_pend) begin
            n_rd[{r_pend_k, 3'b000} +: 8] = w_rbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store && w_rgn == smmd_pkg::RGN_MAIN) begin
            r_main_mem[w_idx[MAIN_AW-1:0]] <= w_wbyte;
        end
        r_main_q <= r_main_mem[w_idx[MAIN_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_store && w_rgn == smmd_pkg::RGN_PAR) begin
            r_par_mem[w_idx[PAR_AW-1:0]] <= w_wbyte;
        end
        r_par_q <= r_par_mem[w_idx[PAR_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_store && w_rgn == smmd_pkg::RGN_SCR) begin
            r_scr_mem[w_idx[SCR_AW-1:0]] <= w_wbyte;
        end
        r_scr_q <= r_scr_mem[w_idx[SCR_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_store && w_rgn == smmd_pkg::RGN_BOOT) begin
            r_boot_mem[w_idx[BOOT_AW-1:0]] <= w_wbyte;
        end
        r_boot_q <= r_boot_mem[w_idx[BOOT_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_store && w_rgn == smmd_pkg::RGN_CC) begin
            r_cc_mem[w_idx[CC_AW-1:0]] <= w_wbyte;
        end
        r_cc_q <= r_cc_mem[w_idx[CC_AW-1:0]];
    end

    // Result register, loaded in the closing cycle of each access.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_access_fault  <= r_item.bus_err;
            r_read_data     <= (r_item.bus_err || r_item.op == smmd_pkg::OP_STORE) ? '0 : n_rd;
            r_io_request    <= r_item.io_req;
            r_io_write      <= r_item.io_req && (r_item.op == smmd_pkg::OP_STORE);
            r_io_offset     <= r_item.io_off;
            r_io_size       <= r_item.io_req ? r_item.size : 2'd0;
            r_io_write_data <= r_item.io_wdata;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_read_data     = r_read_data;
    assign o_access_fault  = r_access_fault;
    assign o_io_request    = r_io_request;
    assign o_io_write      = r_io_write;
    assign o_io_offset     = r_io_offset;
    assign o_io_size       = r_io_size;
    assign o_io_write_data = r_io_write_data;

endmodule
